### rtl/multi_cpu_preemptive_scheduler_assert.svh
// Assertion macros for the multiprocessor scheduler.
`ifndef MULTI_CPU_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define MULTI_CPU_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MCPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MCPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MCPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mcps_pkg.sv
// Shared types, constants and key function of the scheduler.
`default_nettype none
package mcps_pkg;
  localparam int NUM_CPUS    = 4;
  localparam int READY_DEPTH = 16;
  localparam int CPU_W       = 2;
  localparam int CPU_CW      = 3;
  localparam int RDY_AW      = 4;
  localparam int RDY_CW      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_CPU    = 2'd2;
  localparam logic OP_TICK   = 1'b1;
  localparam logic MODE_SRTF = 1'b1;
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_CPUS   = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] rem;
  } task_t;

  typedef struct packed {
    logic  is_tick;
    task_t tsk;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CPU_W-1:0] cpu;
    logic             busy;
    logic [7:0]       id;
    logic [15:0]      left;
    logic             fin;
    logic             last;
  } result_t;

  function automatic logic [15:0] key_of(input logic mode, input task_t t);
    key_of = (mode == MODE_SRTF) ? t.rem : {8'd0, t.prio};
  endfunction
endpackage
`default_nettype wire

### rtl/mcps_front.sv
// Front end: takes items, tags ticks and arrivals, buffers them in a short queue.
`default_nettype none
module mcps_front import mcps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [7:0]  in_task_priority,
  input  wire logic [15:0] in_task_duration,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);
  item_t             buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;

  assign busy    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r].is_tick  <= (in_opcode == OP_TICK);
      buf_r[wp_r].tsk.id   <= in_task_id;
      buf_r[wp_r].tsk.prio <= in_task_priority;
      buf_r[wp_r].tsk.rem  <= in_task_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

### rtl/mcps_engine.sv
// Back end: ready list memory, CPU slots and the placement/run sequencer.
`default_nettype none
module mcps_engine import mcps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       policy_mode,
  input  wire logic [2:0] cpus_in_use,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  output logic            res_valid,
  output result_t         res
);
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_PLACE    = 8'b0000_1000,
    S_RM_RD    = 8'b0001_0000,
    S_RM_WR    = 8'b0010_0000,
    S_APPEND   = 8'b0100_0000,
    S_RUN      = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  task_t               mem [READY_DEPTH];
  task_t               rd_data_r;
  logic [RDY_AW-1:0]   rd_addr, wr_addr;
  logic                we;
  task_t               wr_data;
  logic [RDY_CW-1:0]   count_r, count_nxt;
  logic [RDY_CW-1:0]   j_r, j_nxt;
  logic [RDY_AW-1:0]   best_r, best_nxt;
  task_t               beste_r, beste_nxt;
  task_t               evict_r, evict_nxt;
  logic                pend_r, pend_nxt;
  logic [NUM_CPUS-1:0] sv_r, sv_nxt;
  task_t               st_r [NUM_CPUS];
  task_t               st_nxt [NUM_CPUS];
  logic [CPU_CW-1:0]   n_r, n_nxt, n_act;
  logic [CPU_W-1:0]    ri_r, ri_nxt;
  logic                rv_nxt;
  result_t             res_nxt;
  logic                free_hit, pre_hit, last;
  logic [CPU_W-1:0]    free_i, pre_i;
  logic [15:0]         worst_key, cur_rem;
  logic [RDY_CW-1:0]   j_inc;

  // active slot count: zero reads as one, capped at the slot count
  always_comb begin
    n_act = cpus_in_use;
    if (n_act == '0) n_act = CPU_CW'(1);
    if (n_act > CPU_CW'(NUM_CPUS)) n_act = CPU_CW'(NUM_CPUS);
  end

  // lowest free active slot, and slot with strictly greatest key above the pick
  always_comb begin
    free_hit  = 1'b0;
    free_i    = '0;
    pre_hit   = 1'b0;
    pre_i     = '0;
    worst_key = key_of(policy_mode, beste_r);
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (CPU_CW'(i) < n_r) begin
        if (!sv_r[i] && !free_hit) begin
          free_hit = 1'b1;
          free_i   = CPU_W'(i);
        end
        if (key_of(policy_mode, st_r[i]) > worst_key) begin
          worst_key = key_of(policy_mode, st_r[i]);
          pre_i     = CPU_W'(i);
          pre_hit   = 1'b1;
        end
      end
    end
  end

  assign j_inc   = j_r + 1'b1;
  assign last    = ({1'b0, ri_r} + 1'b1) == n_r;
  assign cur_rem = (st_r[ri_r].rem != '0) ? st_r[ri_r].rem - 1'b1 : '0;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    best_nxt  = best_r;
    beste_nxt = beste_r;
    evict_nxt = evict_r;
    pend_nxt  = pend_r;
    sv_nxt    = sv_r;
    st_nxt    = st_r;
    n_nxt     = n_r;
    ri_nxt    = ri_r;
    rv_nxt    = 1'b0;
    res_nxt   = res;
    q_pop     = 1'b0;
    rd_addr   = j_r[RDY_AW-1:0];
    we        = 1'b0;
    wr_addr   = count_r[RDY_AW-1:0];
    wr_data   = q_item.tsk;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.is_tick) begin
            n_nxt  = n_act;
            ri_nxt = '0;
            j_nxt  = '0;
            state_nxt = (count_r != '0) ? S_SCAN_RD : S_RUN;
          end else begin
            res_nxt.cpu  = '0;
            res_nxt.busy = 1'b0;
            res_nxt.id   = q_item.tsk.id;
            res_nxt.left = q_item.tsk.rem;
            res_nxt.fin  = 1'b0;
            res_nxt.last = 1'b1;
            rv_nxt       = 1'b1;
            if (count_r < RDY_CW'(READY_DEPTH)) begin
              we           = 1'b1;
              count_nxt    = count_r + 1'b1;
              res_nxt.kind = KIND_ACCEPT;
            end else begin
              res_nxt.kind = KIND_DROP;
            end
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (j_r == '0 || key_of(policy_mode, rd_data_r) < key_of(policy_mode, beste_r)) begin
          best_nxt  = j_r[RDY_AW-1:0];
          beste_nxt = rd_data_r;
        end
        j_nxt     = j_inc;
        state_nxt = (j_inc == count_r) ? S_PLACE : S_SCAN_RD;
      end
      S_PLACE: begin
        j_nxt = {1'b0, best_r};
        if (free_hit) begin
          sv_nxt[free_i] = 1'b1;
          st_nxt[free_i] = beste_r;
          pend_nxt       = 1'b0;
          state_nxt      = S_RM_RD;
        end else if (pre_hit) begin
          evict_nxt     = st_r[pre_i];
          st_nxt[pre_i] = beste_r;
          pend_nxt      = 1'b1;
          state_nxt     = S_RM_RD;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RM_RD: begin
        rd_addr = j_inc[RDY_AW-1:0];
        if (j_inc < count_r) begin
          state_nxt = S_RM_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          j_nxt     = '0;
          if (pend_r) state_nxt = S_APPEND;
          else state_nxt = (count_r != RDY_CW'(1)) ? S_SCAN_RD : S_RUN;
        end
      end
      S_RM_WR: begin
        we        = 1'b1;
        wr_addr   = j_r[RDY_AW-1:0];
        wr_data   = rd_data_r;
        j_nxt     = j_inc;
        state_nxt = S_RM_RD;
      end
      S_APPEND: begin
        we        = 1'b1;
        wr_data   = evict_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_RUN: begin
        res_nxt.kind = KIND_CPU;
        res_nxt.cpu  = ri_r;
        res_nxt.last = last;
        rv_nxt       = 1'b1;
        if (sv_r[ri_r]) begin
          res_nxt.busy = 1'b1;
          res_nxt.id   = st_r[ri_r].id;
          res_nxt.left = cur_rem;
          res_nxt.fin  = (cur_rem == '0);
          st_nxt[ri_r].rem = cur_rem;
          if (cur_rem == '0) sv_nxt[ri_r] = 1'b0;
        end else begin
          res_nxt.busy = 1'b0;
          res_nxt.id   = '0;
          res_nxt.left = '0;
          res_nxt.fin  = 1'b0;
        end
        ri_nxt    = ri_r + 1'b1;
        state_nxt = last ? S_IDLE : S_RUN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    best_r  <= best_nxt;
    beste_r <= beste_nxt;
    evict_r <= evict_nxt;
    pend_r  <= pend_nxt;
    st_r    <= st_nxt;
    n_r     <= n_nxt;
    ri_r    <= ri_nxt;
    res     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      sv_r      <= '0;
      res_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sv_r      <= sv_nxt;
      res_valid <= rv_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/multi_cpu_preemptive_scheduler.sv
// Top level of the preemptive multiprocessor scheduler.
//
//  channel  | handshake            | carries
//  ---------+----------------------+----------------------------------------
//  input    | start / busy         | opcode, task id, priority, duration
//  result   | out_valid (strobe)   | kind, cpu, busy, id, time left, fin, last
//  config   | APB psel/penable     | policy mode (0x0), cpus in use (0x4)
//
// An arrival item yields its one registered result once the engine pops it.
// A tick runs placement passes that each scan the ready list, then shift entries
// down on removal and append any evicted task, then reports once per active CPU;
// the registered read port of the ready list memory sets this pace.
// Reset clears the queue, the ready count, all CPU slots and the config registers.
// The receiver cannot stall; busy only rises when the two-item queue is full.
`default_nettype none
`include "multi_cpu_preemptive_scheduler_assert.svh"
module multi_cpu_preemptive_scheduler import mcps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [7:0]  in_task_priority,
  input  wire logic [15:0] in_task_duration,
  output logic             out_valid,
  output logic [1:0]       out_report_kind,
  output logic [1:0]       out_cpu_index,
  output logic             out_cpu_busy,
  output logic [7:0]       out_running_id,
  output logic [15:0]      out_time_left,
  output logic             out_task_finished,
  output logic             out_last_report,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic       policy_r;
  logic [2:0] cpus_r;
  logic       cfg_wr;
  logic       q_valid, q_pop;
  item_t      q_item;
  result_t    res;

  // register index sits at paddr[2]; low bits are byte offsets
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = {31'd0, policy_r};
      REG_CPUS:   prdata = {29'd0, cpus_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      cpus_r   <= 3'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POLICY) policy_r <= pwdata[0];
      else cpus_r <= pwdata[2:0];
    end
  end

  mcps_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_task_id, .in_task_priority, .in_task_duration,
    .q_valid, .q_item, .q_pop
  );

  mcps_engine u_engine (
    .clk, .rst_n,
    .policy_mode (policy_r),
    .cpus_in_use (cpus_r),
    .q_valid, .q_item, .q_pop,
    .res_valid   (out_valid),
    .res
  );

  assign out_report_kind   = res.kind;
  assign out_cpu_index     = res.cpu;
  assign out_cpu_busy      = res.busy;
  assign out_running_id    = res.id;
  assign out_time_left     = res.left;
  assign out_task_finished = res.fin;
  assign out_last_report   = res.last;

  // arrival results are always single
  `MCPS_ASSERT_IMPL(a_arr_last, clk, rst_n, out_valid && out_report_kind != KIND_CPU, out_last_report, "arrival result not marked last")
  `MCPS_ASSERT_IMPL(a_kind_ok, clk, rst_n, out_valid, out_report_kind != 2'd3, "bad report kind")
  `MCPS_ASSERT_IMPL(a_idle_zero, clk, rst_n, out_valid && out_report_kind == KIND_CPU && !out_cpu_busy, out_running_id == 8'd0 && out_time_left == 16'd0 && !out_task_finished, "idle slot report not zero")
  `MCPS_ASSERT_IMPL(a_fin_zero, clk, rst_n, out_valid && out_task_finished, out_time_left == 16'd0, "finished task with time left")
endmodule
`default_nettype wire
